// ----- src/rotated_bitmap_pixel_writer_defines.svh -----
// assertion macros used by the pixel writer top level
`ifndef ROTATED_BITMAP_PIXEL_WRITER_DEFINES_SVH
`define ROTATED_BITMAP_PIXEL_WRITER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RBPW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbpw assertion failed");

// next-cycle implication, checked out of reset
`define RBPW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbpw assertion failed");

`endif

// ----- src/rbpw_pkg.sv -----
// shared types and constants of the rotated bitmap pixel writer
`default_nettype none

package rbpw_pkg;

    localparam int DEF_WIDTH_PIXELS  = 200;
    localparam int DEF_HEIGHT_PIXELS = 200;

    localparam int COORD_W    = 10;
    localparam int ADDR_OUT_W = 13;
    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int XF_W       = 12;   // signed width of transform arithmetic

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR   = 1'd1;

    // rotation codes
    localparam logic [MODE_W-1:0] ROT_NONE = 2'd0;
    localparam logic [MODE_W-1:0] ROT_90   = 2'd1;
    localparam logic [MODE_W-1:0] ROT_180  = 2'd2;
    localparam logic [MODE_W-1:0] ROT_270  = 2'd3;

    // mirror bit positions
    localparam int MIR_H_BIT = 0;
    localparam int MIR_V_BIT = 1;

    // command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               pixel_on;
    } in_item_t;

    typedef struct packed {
        logic                  applied;
        logic [ADDR_OUT_W-1:0] byte_address;
        logic [BYTE_W-1:0]     byte_value;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_XFORM,
        ST_ADDR,
        ST_READ,
        ST_WRITE,
        ST_DROP,
        ST_CLEAR,
        ST_CLEAR_DONE
    } state_t;

    typedef enum logic [1:0] {
        RES_DROP,
        RES_WRITE,
        RES_CLEAR
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      sweep_clr;
        logic      sweep_step;
        logic      pix_write;
        logic      load_out;
        res_kind_t res_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic ok;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/rbpw_in_if.sv -----
// input channel interface: pixel and clear commands
`default_nettype none

interface rbpw_in_if;
    logic               valid;
    logic               ready;
    rbpw_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/rbpw_out_if.sv -----
// output channel interface: write results
`default_nettype none

interface rbpw_out_if;
    logic                valid;
    logic                ready;
    rbpw_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/rotated_bitmap_pixel_writer.sv -----
// top level of the rotated one-bit-per-pixel frame store writer
`default_nettype none
`include "rotated_bitmap_pixel_writer_defines.svh"

// Keeps a monochrome frame store of HEIGHT_PIXELS rows of ceil(WIDTH_PIXELS/8)
// bytes each, msb leftmost. A pixel command is bounds checked, rotated by the
// rotation register, mirrored by the mirror register and then sets or clears
// one bit by read-modify-write of a single store byte; its result carries the
// byte address and the new byte. A dropped pixel returns all-zero fields. A
// clear command zeroes every byte and returns applied with zero address and
// value. Every command gives exactly one result. Order of work, set by the
// sequencer and the single store write port: a pixel write steps through
// accept, transform, address multiply, store read, modify and write before the
// next transfer is accepted, a dropped pixel skips the store read and write, and
// a clear zeroes the store one byte per cycle. After reset the same clearing
// pass runs with input ready low; config writes are taken throughout. The result
// sits in an output register, so the next command is accepted while an earlier
// result still waits for its transfer. Config writes are expected only while the
// block is idle.

module rotated_bitmap_pixel_writer #(
    parameter int WIDTH_PIXELS  = rbpw_pkg::DEF_WIDTH_PIXELS,
    parameter int HEIGHT_PIXELS = rbpw_pkg::DEF_HEIGHT_PIXELS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rbpw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbpw_pkg::MODE_W-1:0]    cfg_wdata,
    rbpw_in_if.sink                             pix_in,
    rbpw_out_if.source                          pix_out
);

    localparam int WIDTH_BYTES = (WIDTH_PIXELS + 7) / 8;
    localparam int STORE_BYTES = WIDTH_BYTES * HEIGHT_PIXELS;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    rbpw_pkg::ctrl_cmd_t  cmd;
    rbpw_pkg::dp_status_t status;

    // frame store port
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [rbpw_pkg::BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [rbpw_pkg::BYTE_W-1:0] ram_rdata;

    logic in_fire;

    assign in_fire = pix_in.valid && pix_in.ready;

    // sequencer: one command in flight
    rbpw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (pix_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // transform, address, byte update and result register
    rbpw_dp #(
        .WIDTH_PIXELS  (WIDTH_PIXELS),
        .HEIGHT_PIXELS (HEIGHT_PIXELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (pix_in.data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (pix_out.ready),
        .out_valid (pix_out.valid),
        .out_data  (pix_out.data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // frame store, contents undefined until the clearing pass after reset
    rbpw_ram #(
        .DATA_W (rbpw_pkg::BYTE_W),
        .DEPTH  (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a new command only after the current one has finished
    `RBPW_ASSERT_NEXT(a_one_in_flight, in_fire, !pix_in.ready)
    // the store is never written while a command may be accepted
    `RBPW_ASSERT_IMPL(a_store_busy, ram_we, !pix_in.ready)
    // a dropped pixel shows zero address and value
    `RBPW_ASSERT_IMPL(a_drop_zero, pix_out.valid && !pix_out.data.applied, pix_out.data == '0)

endmodule

`default_nettype wire

// ----- src/rbpw_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module rbpw_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 5000,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/rbpw_ctrl.sv -----
// controller state machine of the pixel writer
`default_nettype none

module rbpw_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rbpw_pkg::dp_status_t status,
    output rbpw_pkg::ctrl_cmd_t       cmd
);

    rbpw_pkg::state_t state_reg;
    rbpw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbpw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbpw_pkg::ST_INIT:
            begin
                if (status.sweep_last)
                begin
                    state_next = rbpw_pkg::ST_IDLE;
                end
            end
            rbpw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rbpw_pkg::ST_XFORM;
                end
            end
            rbpw_pkg::ST_XFORM:
            begin
                state_next = status.is_clear ? rbpw_pkg::ST_CLEAR : rbpw_pkg::ST_ADDR;
            end
            rbpw_pkg::ST_ADDR:
            begin
                state_next = status.ok ? rbpw_pkg::ST_READ : rbpw_pkg::ST_DROP;
            end
            rbpw_pkg::ST_READ:
            begin
                state_next = rbpw_pkg::ST_WRITE;
            end
            rbpw_pkg::ST_WRITE, rbpw_pkg::ST_DROP, rbpw_pkg::ST_CLEAR_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = rbpw_pkg::ST_IDLE;
                end
            end
            rbpw_pkg::ST_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = rbpw_pkg::ST_CLEAR_DONE;
                end
            end
            default:
            begin
                state_next = rbpw_pkg::ST_INIT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd.capture    = 1'b0;
        cmd.sweep_clr  = 1'b0;
        cmd.sweep_step = 1'b0;
        cmd.pix_write  = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.res_kind   = rbpw_pkg::RES_DROP;
        case (state_reg)
            rbpw_pkg::ST_INIT, rbpw_pkg::ST_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
            end
            rbpw_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.capture   = in_valid;
                cmd.sweep_clr = in_valid;
            end
            rbpw_pkg::ST_WRITE:
            begin
                cmd.pix_write = status.out_free;
                cmd.load_out  = status.out_free;
                cmd.res_kind  = rbpw_pkg::RES_WRITE;
            end
            rbpw_pkg::ST_DROP:
            begin
                cmd.load_out = status.out_free;
                cmd.res_kind = rbpw_pkg::RES_DROP;
            end
            rbpw_pkg::ST_CLEAR_DONE:
            begin
                cmd.load_out = status.out_free;
                cmd.res_kind = rbpw_pkg::RES_CLEAR;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/rbpw_dp.sv -----
// datapath: config registers, coordinate transform, address, byte update, result register
`default_nettype none

module rbpw_dp #(
    parameter int WIDTH_PIXELS  = rbpw_pkg::DEF_WIDTH_PIXELS,
    parameter int HEIGHT_PIXELS = rbpw_pkg::DEF_HEIGHT_PIXELS,
    localparam int WIDTH_BYTES = (WIDTH_PIXELS + 7) / 8,
    localparam int STORE_BYTES = WIDTH_BYTES * HEIGHT_PIXELS,
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rbpw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rbpw_pkg::MODE_W-1:0]        cfg_wdata,
    input  wire rbpw_pkg::in_item_t                 in_data,
    input  wire rbpw_pkg::ctrl_cmd_t                cmd,
    output rbpw_pkg::dp_status_t                    status,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output rbpw_pkg::out_item_t                     out_data,
    output logic                                    ram_we,
    output logic [ADDR_W-1:0]                       ram_waddr,
    output logic [rbpw_pkg::BYTE_W-1:0]             ram_wdata,
    output logic [ADDR_W-1:0]                       ram_raddr,
    input  wire logic [rbpw_pkg::BYTE_W-1:0]        ram_rdata
);

    localparam logic signed [rbpw_pkg::XF_W-1:0] W_LIM = rbpw_pkg::XF_W'(WIDTH_PIXELS);
    localparam logic signed [rbpw_pkg::XF_W-1:0] H_LIM = rbpw_pkg::XF_W'(HEIGHT_PIXELS);
    localparam logic signed [rbpw_pkg::XF_W-1:0] W_MAX = rbpw_pkg::XF_W'(WIDTH_PIXELS - 1);
    localparam logic signed [rbpw_pkg::XF_W-1:0] H_MAX = rbpw_pkg::XF_W'(HEIGHT_PIXELS - 1);

    logic [rbpw_pkg::MODE_W-1:0]  rot_reg;
    logic [rbpw_pkg::MODE_W-1:0]  mir_reg;
    logic                         cmd_reg;
    logic [rbpw_pkg::COORD_W-1:0] x_reg;
    logic [rbpw_pkg::COORD_W-1:0] y_reg;
    logic                         on_reg;
    logic [rbpw_pkg::COORD_W-1:0] xt_reg;
    logic [rbpw_pkg::COORD_W-1:0] yt_reg;
    logic                         ok_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [2:0]                   bit_reg;
    logic [ADDR_W-1:0]            sweep_reg;
    logic                         out_valid_reg;
    rbpw_pkg::out_item_t          out_data_reg;
    rbpw_pkg::out_item_t          out_data_next;

    logic signed [rbpw_pkg::XF_W-1:0] xs;
    logic signed [rbpw_pkg::XF_W-1:0] ys;
    logic signed [rbpw_pkg::XF_W-1:0] xa;
    logic signed [rbpw_pkg::XF_W-1:0] ya;
    logic signed [rbpw_pkg::XF_W-1:0] xb;
    logic signed [rbpw_pkg::XF_W-1:0] yb;
    logic                             ok_next;
    logic [ADDR_W-1:0]                addr_next;
    logic [rbpw_pkg::BYTE_W-1:0]      bit_mask;
    logic [rbpw_pkg::BYTE_W-1:0]      new_byte;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg <= rbpw_pkg::ROT_NONE;
            mir_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbpw_pkg::CFG_ROTATION: rot_reg <= cfg_wdata;
                rbpw_pkg::CFG_MIRROR:   mir_reg <= cfg_wdata;
                default:                rot_reg <= rot_reg;
            endcase
        end
    end

    // captured command
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= in_data.command;
            x_reg   <= in_data.pixel_x;
            y_reg   <= in_data.pixel_y;
            on_reg  <= in_data.pixel_on;
        end
    end

    // rotation then mirroring, signed so out-of-panel results are caught
    always_comb
    begin
        xs = rbpw_pkg::XF_W'(x_reg);
        ys = rbpw_pkg::XF_W'(y_reg);
        case (rot_reg)
            rbpw_pkg::ROT_90:
            begin
                xa = ys;
                ya = H_MAX - xs;
            end
            rbpw_pkg::ROT_180:
            begin
                xa = W_MAX - xs;
                ya = H_MAX - ys;
            end
            rbpw_pkg::ROT_270:
            begin
                xa = W_MAX - ys;
                ya = xs;
            end
            default:
            begin
                xa = xs;
                ya = ys;
            end
        endcase
        xb = mir_reg[rbpw_pkg::MIR_H_BIT] ? (W_MAX - xa) : xa;
        yb = mir_reg[rbpw_pkg::MIR_V_BIT] ? (H_MAX - ya) : ya;
        ok_next = (xs < W_LIM) && (ys < H_LIM)
                  && (xb >= 0) && (xb < W_LIM) && (yb >= 0) && (yb < H_LIM);
    end

    assign addr_next = ADDR_W'(yt_reg) * ADDR_W'(WIDTH_BYTES) + ADDR_W'(xt_reg >> 3);

    always_ff @(posedge clk)
    begin
        xt_reg   <= xb[rbpw_pkg::COORD_W-1:0];
        yt_reg   <= yb[rbpw_pkg::COORD_W-1:0];
        ok_reg   <= ok_next;
        addr_reg <= addr_next;
        bit_reg  <= xt_reg[2:0];
    end

    // msb is the leftmost pixel
    assign bit_mask = 8'h80 >> bit_reg;
    assign new_byte = on_reg ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep_clr)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep_step)
        begin
            sweep_reg <= sweep_reg + ADDR_W'(1);
        end
    end

    assign ram_we    = cmd.sweep_step || cmd.pix_write;
    assign ram_waddr = cmd.sweep_step ? sweep_reg : addr_reg;
    assign ram_wdata = cmd.pix_write ? new_byte : '0;
    assign ram_raddr = addr_reg;

    // result register
    always_comb
    begin
        out_data_next = '0;
        case (cmd.res_kind)
            rbpw_pkg::RES_WRITE:
            begin
                out_data_next.applied      = 1'b1;
                out_data_next.byte_address = rbpw_pkg::ADDR_OUT_W'(addr_reg);
                out_data_next.byte_value   = new_byte;
            end
            rbpw_pkg::RES_CLEAR:
            begin
                out_data_next.applied = 1'b1;
            end
            default:
            begin
                out_data_next.applied = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.is_clear   = (cmd_reg == rbpw_pkg::CMD_CLEAR);
    assign status.ok         = ok_reg;
    assign status.sweep_last = (sweep_reg == ADDR_W'(STORE_BYTES - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// ----- dv/pixel_write_checker.sv -----
// checker for the pixel writer: follows every transfer, predicts each result and compares it
`timescale 1ns / 100ps

module pixel_write_checker
    import rbpw_pkg::*;
#(
    parameter int WIDTH_PIXELS  = DEF_WIDTH_PIXELS,
    parameter int HEIGHT_PIXELS = DEF_HEIGHT_PIXELS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MODE_W-1:0]    cfg_wdata,
    rbpw_in_if                   pix_in,
    rbpw_out_if                  pix_out,
    output int                   fail_count,
    output int                   outstanding
);
    localparam int ROW_BYTES    = (WIDTH_PIXELS + 7) / 8;
    localparam int STORE_BYTES  = ROW_BYTES * HEIGHT_PIXELS;
    localparam int REPORT_LIMIT = 10;

    logic [BYTE_W-1:0] shadow_store [STORE_BYTES];
    logic [MODE_W-1:0] rotation;
    logic [MODE_W-1:0] mirror;
    out_item_t         pending_writes [$];
    out_item_t         oldest;
    out_item_t         got;
    int                mismatches;

    // updates the shadow store and returns the result the block should give
    function automatic out_item_t apply_pixel_command(input in_item_t cmd);
        out_item_t         res;
        int                col;
        int                row;
        int                held;
        int                addr;
        logic [BYTE_W-1:0] value;
        res = '0;
        if (cmd.command == CMD_CLEAR) begin
            foreach (shadow_store[i])
                shadow_store[i] = '0;
            res.applied = 1'b1;
            return res;
        end
        col = int'(cmd.pixel_x);
        row = int'(cmd.pixel_y);
        if (col >= WIDTH_PIXELS || row >= HEIGHT_PIXELS)
            return res;
        case (rotation)
            ROT_90:
            begin
                held = col;
                col  = row;
                row  = HEIGHT_PIXELS - 1 - held;
            end
            ROT_180:
            begin
                col = WIDTH_PIXELS - 1 - col;
                row = HEIGHT_PIXELS - 1 - row;
            end
            ROT_270:
            begin
                held = col;
                col  = WIDTH_PIXELS - 1 - row;
                row  = held;
            end
            default: ;
        endcase
        if (mirror[MIR_H_BIT])
            col = WIDTH_PIXELS - 1 - col;
        if (mirror[MIR_V_BIT])
            row = HEIGHT_PIXELS - 1 - row;
        // a non-square panel can rotate a pixel off the store
        if (col < 0 || col >= WIDTH_PIXELS || row < 0 || row >= HEIGHT_PIXELS)
            return res;
        addr  = row * ROW_BYTES + col / BYTE_W;
        value = shadow_store[addr];
        value[BYTE_W - 1 - (col % BYTE_W)] = cmd.pixel_on;
        shadow_store[addr] = value;
        res.applied      = 1'b1;
        res.byte_address = ADDR_OUT_W'(addr);
        res.byte_value   = value;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (shadow_store[i])
                shadow_store[i] = '0;
            rotation = ROT_NONE;
            mirror   = '0;
            pending_writes.delete();
            mismatches = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROTATION)
                    rotation = cfg_wdata;
                else if (cfg_index == CFG_MIRROR)
                    mirror = cfg_wdata;
            end
            // the result leaving now belongs to an earlier command
            if (pix_out.valid && pix_out.ready)
            begin
                got = pix_out.data;
                if (pending_writes.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected result: applied %0d address %0d value %02h",
                                 got.applied, got.byte_address, got.byte_value);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_writes.pop_front();
                    if (got.applied !== oldest.applied
                        || got.byte_address !== oldest.byte_address
                        || got.byte_value !== oldest.byte_value)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"result mismatch: expected applied %0d address %0d",
                                      " value %02h, got applied %0d address %0d value %02h"},
                                     oldest.applied, oldest.byte_address, oldest.byte_value,
                                     got.applied, got.byte_address, got.byte_value);
                        mismatches++;
                    end
                end
            end
            if (pix_in.valid && pix_in.ready)
                pending_writes.push_back(apply_pixel_command(pix_in.data));
            fail_count  <= mismatches;
            outstanding <= pending_writes.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// testbench top for the rotated bitmap pixel writer: stimulus, pacing and verdict
`timescale 1ns / 100ps

module tb_top;
    import rbpw_pkg::*;

    localparam int WIDTH_PX          = DEF_WIDTH_PIXELS;
    localparam int HEIGHT_PX         = DEF_HEIGHT_PIXELS;
    localparam int PHASE_ITEMS       = 27;     // random commands per mode setting
    localparam int MAX_RANDOM_CLEARS = 12;     // each clear sweeps the whole store
    localparam int CALM_FROM_PHASE   = 14;     // last two settings run with no idling
    localparam int SETTLE_CYCLES     = 8;      // longer than one read-modify-write
    localparam int LIMIT_CYCLES      = 400000;

    // mirror codes, one bit per axis
    localparam logic [MODE_W-1:0] MIR_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MIR_H    = 2'd1;
    localparam logic [MODE_W-1:0] MIR_V    = 2'd2;
    localparam logic [MODE_W-1:0] MIR_BOTH = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MODE_W-1:0]    cfg_wdata;

    rbpw_in_if  pix_in ();
    rbpw_out_if pix_out ();

    int fail_count;
    int outstanding;
    int cycle_count;

    // pacing and stimulus shaping
    bit calm;
    int send_odds;
    int sink_odds;
    int sink_span;
    int clears_left;
    int cluster_x;
    int cluster_y;
    int phase;

    logic [MODE_W-1:0] rotation_codes [4];
    logic [MODE_W-1:0] mirror_codes [4];

    rotated_bitmap_pixel_writer #(
        .WIDTH_PIXELS  (WIDTH_PX),
        .HEIGHT_PIXELS (HEIGHT_PX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pix_in    (pix_in),
        .pix_out   (pix_out)
    );

    pixel_write_checker #(
        .WIDTH_PIXELS  (WIDTH_PX),
        .HEIGHT_PIXELS (HEIGHT_PX)
    ) scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .pix_in      (pix_in),
        .pix_out     (pix_out),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // result side backpressure: ready drops for bursts of random length, with the
    // stall rate picked again every 128 loop passes so some stretches never stall
    initial
    begin
        pix_out.ready <= 1'b0;
        sink_span = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_span == 0)
            begin
                sink_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
                sink_span = 128;
            end
            sink_span--;
            if (!calm && sink_odds != 0 && $urandom_range(1, sink_odds) == 1)
            begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            pix_out.ready <= 1'b1;
        end
    end

    function automatic in_item_t make_command(input logic cmd, input int x, input int y,
                                              input logic on);
        in_item_t item;
        item.command  = cmd;
        item.pixel_x  = COORD_W'(x);
        item.pixel_y  = COORD_W'(y);
        item.pixel_on = on;
        return item;
    endfunction

    // idle gap before the next command, none while calm
    function automatic int pick_gap();
        if (calm || send_odds == 0)
            return 0;
        if ($urandom_range(1, send_odds) == 1)
            return $urandom_range(1, 16);
        return 0;
    endfunction

    // mostly pixels packed into a small window so bytes fill up over several
    // writes, plus scattered pixels, corners, out of range and a few clears
    function automatic in_item_t random_command();
        int roll;
        int x;
        int y;
        roll = $urandom_range(0, 99);
        if (roll < 2 && clears_left > 0)
        begin
            clears_left--;
            return make_command(CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                1'($urandom_range(0, 1)));
        end
        if (roll < 52)
        begin
            x = cluster_x + $urandom_range(0, 15);
            y = cluster_y + $urandom_range(0, 3);
        end
        else if (roll < 77)
        begin
            x = $urandom_range(0, WIDTH_PX - 1);
            y = $urandom_range(0, HEIGHT_PX - 1);
        end
        else if (roll < 87)
        begin
            x = $urandom_range(0, 1) ? WIDTH_PX - 1 : 0;
            y = $urandom_range(0, 1) ? HEIGHT_PX - 1 : 0;
        end
        else
        begin
            // full field range, mostly off the panel
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 1023);
        end
        return make_command(CMD_PIXEL, x, y, $urandom_range(0, 9) < 7);
    endfunction

    // valid stays high across back-to-back transfers
    task automatic send_command(input in_item_t item, input int gap);
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.data  <= item;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
    endtask

    // drain every result, then give the block time to finish its last store write
    task automatic finish_phase();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers on consecutive edges, write enable held across them
    task automatic set_modes(input logic [MODE_W-1:0] rot, input logic [MODE_W-1:0] mir);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROTATION;
        cfg_wdata <= rot;
        @(posedge clk);
        cfg_index <= CFG_MIRROR;
        cfg_wdata <= mir;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        // every block input known from time zero
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_ROTATION;
        cfg_wdata    <= ROT_NONE;
        pix_in.valid <= 1'b0;
        pix_in.data  <= '0;
        rst_n        <= 1'b0;
        calm         = 1'b0;
        send_odds    = 4;
        clears_left  = MAX_RANDOM_CLEARS;
        cluster_x    = 0;
        cluster_y    = 0;
        rotation_codes = '{ROT_NONE, ROT_270, ROT_90, ROT_180};
        mirror_codes   = '{MIR_NONE, MIR_BOTH, MIR_H, MIR_V};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // config is taken during the power-up sweep, commands wait for it
        set_modes(ROT_NONE, MIR_NONE);

        // directed: corners, field extremes, out of range, clears
        send_command(make_command(CMD_PIXEL, 0, 0, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, 7, 0, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, WIDTH_PX - 1, HEIGHT_PX - 1, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, WIDTH_PX - 1, 0, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, 0, HEIGHT_PX - 1, 1'b1), pick_gap());
        // clear a bit that is set, keeping its neighbor
        send_command(make_command(CMD_PIXEL, 0, 0, 1'b0), pick_gap());
        // just past each bound, then the far ends of the fields
        send_command(make_command(CMD_PIXEL, WIDTH_PX, 0, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, 0, HEIGHT_PX, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, 1023, 1023, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, 1023, 0, 1'b0), pick_gap());
        send_command(make_command(CMD_PIXEL, 0, 1023, 1'b0), pick_gap());
        send_command(make_command(CMD_PIXEL, 512, 256, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, WIDTH_PX - 1, HEIGHT_PX - 1, 1'b0), pick_gap());
        send_command(make_command(CMD_PIXEL, 8, 1, 1'b1), pick_gap());
        // clear with all other fields set, then a write must see an empty byte
        send_command(make_command(CMD_CLEAR, 1023, 1023, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, 7, 0, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, 0, 0, 1'b0), pick_gap());
        send_command(make_command(CMD_CLEAR, 0, 0, 1'b0), pick_gap());
        // a plain pixel, then alternating bit patterns in both coordinates
        send_command(make_command(CMD_PIXEL, 3, 100, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, 170, 85, 1'b1), pick_gap());
        send_command(make_command(CMD_PIXEL, 85, 170, 1'b1), pick_gap());
        finish_phase();

        // random part: every rotation with every mirroring, extremes first
        phase = 0;
        foreach (rotation_codes[r])
        begin
            foreach (mirror_codes[m])
            begin
                if (phase >= CALM_FROM_PHASE)
                    calm = 1'b1;
                set_modes(rotation_codes[r], mirror_codes[m]);
                send_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
                cluster_x = BYTE_W * $urandom_range(0, (WIDTH_PX - 1) / BYTE_W);
                cluster_y = $urandom_range(0, HEIGHT_PX - 1);
                repeat (PHASE_ITEMS)
                    send_command(random_command(), pick_gap());
                finish_phase();
                phase++;
            end
        end

        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
